// File: design/npce_pkg.sv
package npce_pkg;

	localparam int PAL_ENTRIES = 256;
	localparam int PAL_AW = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
	localparam int CHAN_W = 8;
	localparam int SLOT_W = 8;
	localparam int CODE_W = 16;
	localparam int ENTRY_W = 3 * CHAN_W;
	localparam int SCORE_W = CHAN_W + 2;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_CONVERT = 1'b1;

	localparam logic MODE_PALETTE = 1'b0;
	localparam logic MODE_BGR565 = 1'b1;

	typedef struct packed {
		logic load_wr;
		logic capture;
		logic scan_step;
		logic emit;
	} npce_cmd_t;

	typedef struct packed {
		logic out_free;
		logic scan_last;
		logic pal_mode;
	} npce_status_t;

endpackage

// File: design/npce_ifs.sv
interface npce_pix_if;
	logic valid;
	logic ready;
	logic action;
	logic [npce_pkg::SLOT_W-1:0] palette_slot;
	logic [npce_pkg::CHAN_W-1:0] red;
	logic [npce_pkg::CHAN_W-1:0] green;
	logic [npce_pkg::CHAN_W-1:0] blue;

	modport source (output valid, output action, output palette_slot, output red,
		output green, output blue, input ready);
	modport sink (input valid, input action, input palette_slot, input red,
		input green, input blue, output ready);
endinterface

interface npce_code_if;
	logic valid;
	logic ready;
	logic [npce_pkg::CODE_W-1:0] pixel_code;

	modport source (output valid, output pixel_code, input ready);
	modport sink (input valid, input pixel_code, output ready);
endinterface

interface npce_cfg_if;
	logic valid;
	logic ready;
	logic pixel_mode;

	modport source (output valid, output pixel_mode, input ready);
	modport sink (input valid, input pixel_mode, output ready);
endinterface

// File: design/npce_ram.sv
module npce_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: design/npce_ctrl.sv
module npce_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_action,
	output logic                   in_ready,
	input  npce_pkg::npce_status_t status,
	output npce_pkg::npce_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_action == npce_pkg::ACT_LOAD) begin
						cmd.load_wr = 1'b1;
					end else begin
						cmd.capture = 1'b1;
						if (status.pal_mode) begin
							state_d = ST_SCAN;
						end else begin
							state_d = ST_EMIT;
						end
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_last) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: design/npce_dp.sv
module npce_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  npce_pkg::npce_cmd_t           cmd,
	output npce_pkg::npce_status_t        status,
	input  logic [npce_pkg::SLOT_W-1:0]   in_slot,
	input  logic [npce_pkg::CHAN_W-1:0]   in_red,
	input  logic [npce_pkg::CHAN_W-1:0]   in_green,
	input  logic [npce_pkg::CHAN_W-1:0]   in_blue,
	input  logic                          cfg_wr,
	input  logic                          cfg_mode,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [npce_pkg::CODE_W-1:0]   out_code
);

	localparam int AW = npce_pkg::PAL_AW;
	localparam int CW = npce_pkg::CHAN_W;
	localparam int SW = npce_pkg::SCORE_W;

	function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	logic                            mode_q;
	logic [CW-1:0]                   red_q;
	logic [CW-1:0]                   green_q;
	logic [CW-1:0]                   blue_q;
	logic [AW-1:0]                   scan_addr_q;
	logic                            rd_vld_s1;
	logic [AW-1:0]                   idx_s1;
	logic [SW-1:0]                   best_score_q;
	logic [AW-1:0]                   best_idx_q;
	logic                            out_valid_q;
	logic [npce_pkg::CODE_W-1:0]     out_code_q;
	logic [npce_pkg::ENTRY_W-1:0]    rd_entry;
	logic [SW-1:0]                   score;
	logic                            slot_ok;
	logic [npce_pkg::CODE_W-1:0]     packed_code;

	assign slot_ok = (32'(in_slot) < npce_pkg::PAL_ENTRIES);

	npce_ram #(
		.WIDTH (npce_pkg::ENTRY_W),
		.DEPTH (npce_pkg::PAL_ENTRIES)
	) u_palette (
		.clk   (clk),
		.we    (cmd.load_wr && slot_ok),
		.waddr (AW'(in_slot)),
		.wdata ({in_red, in_green, in_blue}),
		.raddr (scan_addr_q),
		.rdata (rd_entry)
	);

	assign score = SW'(abs_diff(red_q, rd_entry[3*CW-1:2*CW]))
		+ SW'(abs_diff(green_q, rd_entry[2*CW-1:CW]))
		+ SW'(abs_diff(blue_q, rd_entry[CW-1:0]));

	assign packed_code = {blue_q[CW-1:CW-5], green_q[CW-1:CW-6], red_q[CW-1:CW-5]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= npce_pkg::MODE_BGR565;
			rd_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				mode_q <= cfg_mode;
			end
			rd_vld_s1 <= cmd.scan_step;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_addr_q;
		if (cmd.capture) begin
			red_q <= in_red;
			green_q <= in_green;
			blue_q <= in_blue;
			scan_addr_q <= '0;
			best_score_q <= '1;
			best_idx_q <= '0;
		end else begin
			if (cmd.scan_step) begin
				scan_addr_q <= scan_addr_q + AW'(1);
			end
			if (rd_vld_s1 && (score < best_score_q)) begin
				best_score_q <= score;
				best_idx_q <= idx_s1;
			end
		end
		if (cmd.emit) begin
			out_code_q <= (mode_q == npce_pkg::MODE_BGR565) ? packed_code
				: npce_pkg::CODE_W'(best_idx_q);
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign status.scan_last = (scan_addr_q == AW'(npce_pkg::PAL_ENTRIES - 1));
	assign status.pal_mode = (mode_q == npce_pkg::MODE_PALETTE);

	assign out_valid = out_valid_q;
	assign out_code = out_code_q;

endmodule

// File: design/nearest_palette_color_encoder.sv
// A load item is written into the palette RAM when it is taken and gives no result.
// A convert item in BGR565 mode goes to ST_EMIT, and its result is registered once the output is free.
// In palette mode the palette RAM is read one entry per cycle in ST_SCAN, then ST_LAST
// and ST_EMIT follow; the block takes one item at a time.
// Reset clears the control state and sets pixel_mode to BGR565; palette contents
// stay undefined until loaded.
module nearest_palette_color_encoder (
	input logic        clk,
	input logic        arst_n,
	npce_pix_if.sink   pix,
	npce_code_if.source code,
	npce_cfg_if.sink   cfg
);

	npce_pkg::npce_cmd_t    cmd;
	npce_pkg::npce_status_t status;

	assign cfg.ready = 1'b1;

	npce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix.valid),
		.in_action (pix.action),
		.in_ready  (pix.ready),
		.status    (status),
		.cmd       (cmd)
	);

	npce_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_slot   (pix.palette_slot),
		.in_red    (pix.red),
		.in_green  (pix.green),
		.in_blue   (pix.blue),
		.cfg_wr    (cfg.valid),
		.cfg_mode  (cfg.pixel_mode),
		.out_valid (code.valid),
		.out_ready (code.ready),
		.out_code  (code.pixel_code)
	);

endmodule
